@@ sv/batch_integer_sorter_unit_macros.svh @@
// assertion macros used by the batch integer sorter rtl
`ifndef BATCH_INTEGER_SORTER_UNIT_MACROS_SVH
`define BATCH_INTEGER_SORTER_UNIT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define BISU_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition never holds
`define BISU_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

`endif

@@ sv/bisu_pkg.sv @@
// package with sizes, slot type, control type and controller states of the batch sorter
`timescale 1ns / 1ps
package bisu_pkg;
	localparam int BATCH_SIZE = 32;
	localparam int VAL_W      = 32;
	localparam int CNT_W      = $clog2(BATCH_SIZE + 1);
	localparam int SETTLE_W   = $clog2(BATCH_SIZE + 1);

	typedef struct packed {
		logic                    vld;
		logic signed [VAL_W-1:0] val;
	} bisu_slot_t;

	typedef struct packed {
		logic shift;
	} bisu_ctl_t;

	typedef enum logic [2:0] {
		ST_LOAD   = 3'b001,
		ST_SETTLE = 3'b010,
		ST_DRAIN  = 3'b100
	} bisu_state_t;
endpackage

@@ sv/batch_integer_sorter_unit.sv @@
// top level of the batch integer sorter: cell chain, controller, output register
// timing: a batch loads at one value per cycle; after the closing transfer the controller
//   waits in ST_SETTLE for values in flight to land, then ST_DRAIN moves one sorted value
//   per cycle into the output register while result_stall is low
// a new batch is not taken until the last one has drained; the settle wait is set by
//   the travel time of a value down the chain of BATCH_SIZE cells
// reset: arst_n clears the chain valid bits, counters, state and output valid
`timescale 1ns / 1ps
`include "batch_integer_sorter_unit_macros.svh"
module batch_integer_sorter_unit import bisu_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    item_valid,
	output logic                    item_stall,
	input  logic signed [VAL_W-1:0] value,
	input  logic                    last,
	output logic                    result_valid,
	input  logic                    result_stall,
	output logic signed [VAL_W-1:0] sorted_value,
	output logic                    final_res,
	output logic                    overflow
);
	bisu_state_t             state_q;
	logic [CNT_W-1:0]        count_q;       // values held in the current batch
	logic                    dropped_q;     // a value of this batch was dropped
	logic                    batch_ovf_q;   // overflow flag of the batch being drained
	logic [SETTLE_W-1:0]     settle_q;
	logic                    out_vld_q;
	logic signed [VAL_W-1:0] out_val_q;
	logic                    out_final_q;
	logic                    out_ovf_q;

	logic       take;
	logic       full;
	logic       drain_go;
	logic       fwd_any;
	bisu_ctl_t  ctl;
	bisu_slot_t ins   [BATCH_SIZE+1];
	bisu_slot_t held  [BATCH_SIZE];
	bisu_slot_t right [BATCH_SIZE];
	logic [BATCH_SIZE-1:0] fwd_vlds;

	// input side: one transfer per cycle while loading
	assign item_stall = (state_q != ST_LOAD);
	assign take       = item_valid && !item_stall;
	assign full       = (count_q == CNT_W'(BATCH_SIZE));

	// values enter cell 0 directly; a value past capacity never enters
	assign ins[0] = '{vld: take && !full, val: value};

	// draining moves the whole chain one cell left when the output register is free
	assign drain_go  = (state_q == ST_DRAIN) && (!out_vld_q || !result_stall);
	assign ctl.shift = drain_go;

	generate
		for (genvar i = 0; i < BATCH_SIZE; i++) begin : g_cell
			if (i == BATCH_SIZE - 1) begin : g_end
				assign right[i] = '{vld: 1'b0, val: held[i].val};
			end else begin : g_mid
				assign right[i] = held[i+1];
			end
			bisu_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctl),
				.ins_in     (ins[i]),
				.right_held (right[i]),
				.held       (held[i]),
				.ins_out    (ins[i+1])
			);
			assign fwd_vlds[i] = ins[i+1].vld;
		end
	endgenerate

	assign fwd_any = |fwd_vlds;

	// controller: load, wait for values in flight to land, then drain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			count_q     <= '0;
			dropped_q   <= 1'b0;
			batch_ovf_q <= 1'b0;
			settle_q    <= '0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (take) begin
						if (last) begin
							state_q     <= ST_SETTLE;
							settle_q    <= SETTLE_W'(BATCH_SIZE);
							batch_ovf_q <= dropped_q || full;
							count_q     <= '0;
							dropped_q   <= 1'b0;
						end else if (full) begin
							dropped_q <= 1'b1;
						end else begin
							count_q <= count_q + CNT_W'(1);
						end
					end
				end
				ST_SETTLE: begin
					if (settle_q == '0) begin
						state_q <= ST_DRAIN;
					end else begin
						settle_q <= settle_q - SETTLE_W'(1);
					end
				end
				ST_DRAIN: begin
					// the chain is packed from cell 0, so an empty cell 1 marks the end
					if (drain_go && !held[1].vld) begin
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// output register parts the drain from the result stall
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (drain_go) begin
			out_vld_q <= 1'b1;
		end else if (!result_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (drain_go) begin
			out_val_q   <= held[0].val;
			out_final_q <= !held[1].vld;
			out_ovf_q   <= batch_ovf_q;
		end
	end

	assign result_valid = out_vld_q;
	assign sorted_value = out_val_q;
	assign final_res    = out_final_q;
	assign overflow     = out_ovf_q;

	`BISU_ASSERT_NEVER(a_count_range, clk, arst_n, count_q > CNT_W'(BATCH_SIZE), "count past capacity")
	`BISU_ASSERT_NEVER(a_no_spill, clk, arst_n, ins[BATCH_SIZE].vld, "value fell off the chain end")
	`BISU_ASSERT_NEVER(a_settled, clk, arst_n, (state_q == ST_DRAIN) && fwd_any, "drain with value in flight")
	`BISU_ASSERT_IMPL(a_drain_nonempty, clk, arst_n, state_q == ST_DRAIN, held[0].vld, "drain on empty chain")
endmodule

@@ sv/bisu_cell.sv @@
// one compare-and-swap cell of the sorting chain
`timescale 1ns / 1ps
module bisu_cell import bisu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  bisu_ctl_t  ctl,
	input  bisu_slot_t ins_in,
	input  bisu_slot_t right_held,
	output bisu_slot_t held,
	output bisu_slot_t ins_out
);
	logic                    held_vld_q;
	logic signed [VAL_W-1:0] held_val_q;
	logic                    fwd_vld_q;
	logic signed [VAL_W-1:0] fwd_val_q;
	bisu_slot_t              nxt_held;
	bisu_slot_t              pass;

	assign held    = '{vld: held_vld_q, val: held_val_q};
	assign ins_out = '{vld: fwd_vld_q, val: fwd_val_q};

	// smaller value stays, larger moves on; ties keep the earlier value here
	always_comb begin
		nxt_held = held;
		pass     = '{vld: 1'b0, val: ins_in.val};
		if (ins_in.vld) begin
			if (!held_vld_q) begin
				nxt_held = ins_in;
			end else if (ins_in.val < held_val_q) begin
				nxt_held = ins_in;
				pass     = held;
			end else begin
				pass = ins_in;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_vld_q <= 1'b0;
			fwd_vld_q  <= 1'b0;
		end else if (ctl.shift) begin
			held_vld_q <= right_held.vld;
			fwd_vld_q  <= 1'b0;
		end else begin
			held_vld_q <= nxt_held.vld;
			fwd_vld_q  <= pass.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			held_val_q <= right_held.val;
		end else begin
			held_val_q <= nxt_held.val;
		end
		fwd_val_q <= pass.val;
	end
endmodule

@@ test/tb_batch_integer_sorter_unit.sv @@
// testbench for the batch integer sorter: directed table, random batches, scoreboard
`timescale 1ns / 1ps
module tb_batch_integer_sorter_unit;
	import bisu_pkg::*;

	// generous cycle budget, many times the slowest correct run
	localparam int CYCLE_LIMIT = 400000;
	// quiet cycles after the last result: settle time of the chain plus a drain
	localparam int TAIL_CYCLES = 2 * BATCH_SIZE + 16;
	// random part runs until about this many transfers have been made
	localparam int RANDOM_ITEMS = 250;

	localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
	localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

	// one sorted value leaving the block
	typedef struct packed {
		logic signed [VAL_W-1:0] sorted_value;
		logic                    final_res;
		logic                    overflow;
	} sorted_out_t;

	// one row of the directed table; typed rows carry their own result
	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic                    last;
		logic                    typed;
		sorted_out_t             want;
	} stim_row_t;

	// how random batch contents are drawn
	typedef enum int {
		VAL_ANY,      // full 32-bit range
		VAL_CLUSTER,  // a handful of small values, lots of ties
		VAL_EDGE      // values at and next to the extremes, plus -1 and 0
	} val_mode_t;

	localparam int DIR_ROWS = 17;
	localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
		// single-value batches: the one value comes straight back, marked final
		'{VAL_MIN, 1'b1, 1'b1, '{VAL_MIN, 1'b1, 1'b0}},
		'{VAL_MAX, 1'b1, 1'b1, '{VAL_MAX, 1'b1, 1'b0}},
		'{32'sd0,  1'b1, 1'b1, '{32'sd0,  1'b1, 1'b0}},
		'{-32'sd1, 1'b1, 1'b1, '{-32'sd1, 1'b1, 1'b0}},
		// mixed batch with a tie and both extremes
		'{32'sd7,  1'b0, 1'b0, '0},
		'{-32'sd7, 1'b0, 1'b0, '0},
		'{32'sd7,  1'b0, 1'b0, '0},
		'{VAL_MAX, 1'b0, 1'b0, '0},
		'{VAL_MIN, 1'b0, 1'b0, '0},
		'{32'sd0,  1'b1, 1'b0, '0},
		// already ascending
		'{-32'sd2, 1'b0, 1'b0, '0},
		'{-32'sd1, 1'b0, 1'b0, '0},
		'{32'sd1,  1'b1, 1'b0, '0},
		// strictly descending, across the sign boundary
		'{32'sd3,  1'b0, 1'b0, '0},
		'{32'sd1,  1'b0, 1'b0, '0},
		'{-32'sd1, 1'b0, 1'b0, '0},
		'{-32'sd3, 1'b1, 1'b0, '0}
	};

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    item_valid = 1'b0;
	logic                    item_stall;
	logic signed [VAL_W-1:0] value = '0;
	logic                    last = 1'b0;
	logic                    result_valid;
	logic                    result_stall = 1'b0;
	logic signed [VAL_W-1:0] sorted_value;
	logic                    final_res;
	logic                    overflow;

	// predictor state: the batch as it would sit in the cell chain
	logic signed [VAL_W-1:0] batch_sorted [BATCH_SIZE];
	int                      held_n = 0;
	logic                    batch_dropped = 1'b0;

	sorted_out_t sorted_expect_q [$];
	int          fail_cnt = 0;
	int          items_sent = 0;
	int          cycle_cnt = 0;
	bit          burst_mode = 1'b0;

	batch_integer_sorter_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.value        (value),
		.last         (last),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.sorted_value (sorted_value),
		.final_res    (final_res),
		.overflow     (overflow)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// idle length: mostly none or short, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic signed [VAL_W-1:0] rand_value(input val_mode_t mode);
		int pick;
		case (mode)
			VAL_CLUSTER: begin
				return $signed($urandom_range(0, 8)) - 4;
			end
			VAL_EDGE: begin
				pick = $urandom_range(0, 5);
				case (pick)
					0: return VAL_MIN;
					1: return VAL_MIN + 1;
					2: return VAL_MAX;
					3: return VAL_MAX - 1;
					4: return -32'sd1;
					default: return 32'sd0;
				endcase
			end
			default: begin
				return $signed($urandom);
			end
		endcase
	endfunction

	// insertion into the ordered batch, ties land after equal values;
	// a closing value releases the whole batch as expected results when emit is set
	task automatic fold_into_sorted_batch(input logic signed [VAL_W-1:0] v, input logic l,
			input bit emit);
		int          pos;
		sorted_out_t o;
		if (held_n < BATCH_SIZE) begin
			pos = held_n;
			while (pos > 0 && batch_sorted[pos-1] > v) begin
				batch_sorted[pos] = batch_sorted[pos-1];
				pos--;
			end
			batch_sorted[pos] = v;
			held_n++;
		end else begin
			// batch full: value is lost, whole batch gets flagged
			batch_dropped = 1'b1;
		end
		if (l) begin
			if (emit) begin
				for (int i = 0; i < held_n; i++) begin
					o.sorted_value = batch_sorted[i];
					o.final_res    = (i == held_n - 1);
					o.overflow     = batch_dropped;
					sorted_expect_q = {sorted_expect_q, o};
				end
			end
			held_n        = 0;
			batch_dropped = 1'b0;
		end
	endtask

	// one input transfer: optional gap, present at the falling edge, hold through stall
	task automatic send_item(input logic signed [VAL_W-1:0] v, input logic l, input bit typed,
			input sorted_out_t want);
		int gap;
		gap = burst_mode ? 0 : pick_gap();
		repeat (gap) begin
			@(negedge clk);
			item_valid <= 1'b0;
		end
		@(negedge clk);
		item_valid <= 1'b1;
		value      <= v;
		last       <= l;
		do
			@(posedge clk);
		while (item_stall);
		// transfer happened at this edge
		items_sent++;
		fold_into_sorted_batch(v, l, !typed);
		if (typed)
			sorted_expect_q = {sorted_expect_q, want};
	endtask

	task automatic send_batch(input int len, input val_mode_t mode);
		for (int i = 0; i < len; i++)
			send_item(rand_value(mode), i == len - 1, 1'b0, '0);
	endtask

	// hold off the sender until every expected result has come out
	task automatic wait_results_out();
		@(negedge clk);
		item_valid <= 1'b0;
		while (sorted_expect_q.size() != 0)
			@(posedge clk);
	endtask

	// receiver: runs of acceptance broken by stalls, sometimes a long clean stretch
	initial begin
		int go_n;
		int stall_n;
		forever begin
			go_n = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 8);
			repeat (go_n) begin
				@(negedge clk);
				result_stall <= 1'b0;
			end
			stall_n = pick_gap();
			repeat (stall_n) begin
				@(negedge clk);
				result_stall <= 1'b1;
			end
		end
	end

	// scoreboard: each result transfer against the oldest expectation
	always @(posedge clk) begin
		sorted_out_t got;
		sorted_out_t want;
		if (arst_n && result_valid && !result_stall) begin
			got.sorted_value = sorted_value;
			got.final_res    = final_res;
			got.overflow     = overflow;
			if (sorted_expect_q.size() == 0) begin
				$error("sorted_value: no result expected, got %0d", $signed(got.sorted_value));
				fail_cnt++;
			end else begin
				want = sorted_expect_q.pop_front();
				if (got.sorted_value !== want.sorted_value) begin
					$error("sorted_value: expected %0d, got %0d",
						$signed(want.sorted_value), $signed(got.sorted_value));
					fail_cnt++;
				end
				if (got.final_res !== want.final_res) begin
					$error("final_res: expected %0b, got %0b", want.final_res, got.final_res);
					fail_cnt++;
				end
				if (got.overflow !== want.overflow) begin
					$error("overflow: expected %0b, got %0b", want.overflow, got.overflow);
					fail_cnt++;
				end
			end
		end
	end

	// watchdog on the cycle count
	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		int        len;
		int        r;
		val_mode_t mode;

		// hold reset, then release it away from the sampling edge
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed table
		for (int i = 0; i < DIR_ROWS; i++)
			send_item(DIR_TABLE[i].value, DIR_TABLE[i].last, DIR_TABLE[i].typed,
				DIR_TABLE[i].want);
		wait_results_out();

		// random part opens with a batch that fills the chain exactly, then two
		// that run past it; both close on a dropped value
		items_sent = 0;
		send_batch(BATCH_SIZE, VAL_ANY);
		send_batch(BATCH_SIZE + 1, VAL_CLUSTER);
		send_batch(BATCH_SIZE + 4, VAL_EDGE);

		while (items_sent < RANDOM_ITEMS) begin
			burst_mode = ($urandom_range(0, 4) == 0);
			r = $urandom_range(0, 99);
			if (r < 70)
				len = $urandom_range(1, 8);
			else if (r < 90)
				len = $urandom_range(9, BATCH_SIZE);
			else
				len = $urandom_range(BATCH_SIZE + 1, BATCH_SIZE + 4);
			r = $urandom_range(0, 2);
			mode = (r == 0) ? VAL_CLUSTER : (r == 1) ? VAL_EDGE : VAL_ANY;
			send_batch(len, mode);
			// now and then let the block run empty before the next batch
			if ($urandom_range(0, 9) == 0)
				wait_results_out();
		end
		burst_mode = 1'b0;

		wait_results_out();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (fail_cnt == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
